FILE: hw/rtl/indexed_dary_min_heap_core_defines.svh
// Assertion macros for the indexed d-ary min-heap core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef INDEXED_DARY_MIN_HEAP_CORE_DEFINES_SVH
`define INDEXED_DARY_MIN_HEAP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted
`define IDMH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset
`define IDMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDMH_ASSERT(lbl, clk, rstn, prop, msg)
`define IDMH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hw/rtl/idmh_pkg.sv
// Shared types, constants and helpers for the indexed d-ary min-heap core.
// No dependencies.
`timescale 1ns / 1ps

package idmh_pkg;

    localparam int NUM_ITEMS   = 256;
    localparam int ID_W        = 8;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 8;
    localparam int CNT_W       = 9;
    localparam int ARITY_W     = 4;
    localparam int MIN_ARITY   = 2;
    localparam int MAX_ARITY   = 8;
    localparam int CHILD_W     = 11;   // holds d*x + d for x < NUM_ITEMS - 1
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = POS_W + RECIP_W;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_DEL_MIN    = 2'd2,
        OP_CHANGE_KEY = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BAD_ID  = 3'd2,
        ST_NOT_IN  = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  item;
        logic [KEY_W-1:0] key;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_SET_STATUS,
        ACT_RD_SLOT0,
        ACT_INSERT,
        ACT_RD_POS,
        ACT_TAKE_MIN,
        ACT_RD_OLD,
        ACT_GOT_OLD,
        ACT_RD_LAST,
        ACT_GOT_LAST,
        ACT_SU_RD,
        ACT_SU_MOVE,
        ACT_SD_RD,
        ACT_SD_SCAN,
        ACT_SD_MOVE,
        ACT_PLACE,
        ACT_FINISH
    } act_t;

    typedef struct packed {
        act_t    act;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    present;
        logic    size_zero;
        logic    x_zero;
        logic    first_ge_size;
        logic    scan_more;
        logic    up_swap;
        logic    down_swap;
        logic    same_last;
        logic    last_le;
        logic    key_lt;
        logic    key_gt;
        logic    out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DM_GOT,
        S_POS_GOT,
        S_OLD_GOT,
        S_TO_LAST,
        S_LAST_GOT,
        S_SU_CHK,
        S_SU_CMP,
        S_SD_START,
        S_SD_SCAN,
        S_SD_DEC,
        S_PLACE,
        S_FINISH
    } state_t;

    // ceil(2^16 / d); exact floor division for 8-bit dividends and d <= 8
    function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/idmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module idmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/idmh_ctrl.sv
// Controller state machine for the min-heap core: sequences datapath actions.
// Depends on idmh_pkg.
`timescale 1ns / 1ps

module idmh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  idmh_pkg::dp_stat_t stat,
    output idmh_pkg::dp_cmd_t  cmd
);

    idmh_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idmh_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idmh_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = idmh_pkg::S_DISPATCH;
                end
            end
            idmh_pkg::S_DISPATCH:
            begin
                unique case (stat.op)
                    idmh_pkg::OP_DEL_MIN:
                        state_next = stat.size_zero ? idmh_pkg::S_FINISH : idmh_pkg::S_DM_GOT;
                    idmh_pkg::OP_INSERT:
                        state_next = stat.present ? idmh_pkg::S_FINISH : idmh_pkg::S_SU_CHK;
                    default:
                        state_next = stat.present ? idmh_pkg::S_POS_GOT : idmh_pkg::S_FINISH;
                endcase
            end
            idmh_pkg::S_DM_GOT:  state_next = idmh_pkg::S_TO_LAST;
            idmh_pkg::S_POS_GOT: state_next = idmh_pkg::S_OLD_GOT;
            idmh_pkg::S_OLD_GOT:
            begin
                priority if (stat.op == idmh_pkg::OP_REMOVE)
                    state_next = idmh_pkg::S_TO_LAST;
                else if (stat.key_lt)
                    state_next = idmh_pkg::S_SU_CHK;
                else if (stat.key_gt)
                    state_next = idmh_pkg::S_SD_START;
                else
                    state_next = idmh_pkg::S_FINISH;
            end
            idmh_pkg::S_TO_LAST: state_next = idmh_pkg::S_LAST_GOT;
            idmh_pkg::S_LAST_GOT:
            begin
                priority if (stat.same_last)
                    state_next = idmh_pkg::S_FINISH;
                else if (stat.last_le)
                    state_next = idmh_pkg::S_SU_CHK;
                else
                    state_next = idmh_pkg::S_SD_START;
            end
            idmh_pkg::S_SU_CHK:
                state_next = stat.x_zero ? idmh_pkg::S_PLACE : idmh_pkg::S_SU_CMP;
            idmh_pkg::S_SU_CMP:
                state_next = stat.up_swap ? idmh_pkg::S_SU_CHK : idmh_pkg::S_PLACE;
            idmh_pkg::S_SD_START:
                state_next = stat.first_ge_size ? idmh_pkg::S_PLACE : idmh_pkg::S_SD_SCAN;
            idmh_pkg::S_SD_SCAN:
                state_next = stat.scan_more ? idmh_pkg::S_SD_SCAN : idmh_pkg::S_SD_DEC;
            idmh_pkg::S_SD_DEC:
                state_next = stat.down_swap ? idmh_pkg::S_SD_START : idmh_pkg::S_PLACE;
            idmh_pkg::S_PLACE:   state_next = idmh_pkg::S_FINISH;
            idmh_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = idmh_pkg::S_IDLE;
                end
            end
            default:             state_next = idmh_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.act  = idmh_pkg::ACT_NONE;
        cmd.code = idmh_pkg::ST_OK;
        in_stall = (state_reg != idmh_pkg::S_IDLE);
        unique case (state_reg)
            idmh_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act = idmh_pkg::ACT_LOAD;
                end
            end
            idmh_pkg::S_DISPATCH:
            begin
                unique case (stat.op)
                    idmh_pkg::OP_DEL_MIN:
                    begin
                        if (stat.size_zero)
                        begin
                            cmd.act  = idmh_pkg::ACT_SET_STATUS;
                            cmd.code = idmh_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.act = idmh_pkg::ACT_RD_SLOT0;
                        end
                    end
                    idmh_pkg::OP_INSERT:
                    begin
                        if (stat.present)
                        begin
                            cmd.act  = idmh_pkg::ACT_SET_STATUS;
                            cmd.code = idmh_pkg::ST_ALREADY;
                        end
                        else
                        begin
                            cmd.act = idmh_pkg::ACT_INSERT;
                        end
                    end
                    default:
                    begin
                        if (stat.present)
                        begin
                            cmd.act = idmh_pkg::ACT_RD_POS;
                        end
                        else
                        begin
                            cmd.act  = idmh_pkg::ACT_SET_STATUS;
                            cmd.code = idmh_pkg::ST_NOT_IN;
                        end
                    end
                endcase
            end
            idmh_pkg::S_DM_GOT:   cmd.act = idmh_pkg::ACT_TAKE_MIN;
            idmh_pkg::S_POS_GOT:  cmd.act = idmh_pkg::ACT_RD_OLD;
            idmh_pkg::S_OLD_GOT:  cmd.act = idmh_pkg::ACT_GOT_OLD;
            idmh_pkg::S_TO_LAST:  cmd.act = idmh_pkg::ACT_RD_LAST;
            idmh_pkg::S_LAST_GOT: cmd.act = idmh_pkg::ACT_GOT_LAST;
            idmh_pkg::S_SU_CHK:
            begin
                if (!stat.x_zero)
                begin
                    cmd.act = idmh_pkg::ACT_SU_RD;
                end
            end
            idmh_pkg::S_SU_CMP:
            begin
                if (stat.up_swap)
                begin
                    cmd.act = idmh_pkg::ACT_SU_MOVE;
                end
            end
            idmh_pkg::S_SD_START:
            begin
                if (!stat.first_ge_size)
                begin
                    cmd.act = idmh_pkg::ACT_SD_RD;
                end
            end
            idmh_pkg::S_SD_SCAN:  cmd.act = idmh_pkg::ACT_SD_SCAN;
            idmh_pkg::S_SD_DEC:
            begin
                if (stat.down_swap)
                begin
                    cmd.act = idmh_pkg::ACT_SD_MOVE;
                end
            end
            idmh_pkg::S_PLACE:    cmd.act = idmh_pkg::ACT_PLACE;
            idmh_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.act = idmh_pkg::ACT_FINISH;
                end
            end
            default:              cmd.act = idmh_pkg::ACT_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/idmh_datapath.sv
// Datapath of the min-heap core: slot and position RAMs, presence bits,
// sift registers, arity register and output register. Depends on idmh_pkg, idmh_ram.
`timescale 1ns / 1ps
`include "indexed_dary_min_heap_core_defines.svh"

module idmh_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [idmh_pkg::ARITY_W-1:0]        cfg_wr_data,
    input  logic [1:0]                          opcode,
    input  logic [idmh_pkg::ID_W-1:0]           item_id,
    input  logic [idmh_pkg::KEY_W-1:0]          new_key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [idmh_pkg::ID_W-1:0]           min_item,
    output logic [2:0]                          status,
    output logic [idmh_pkg::CNT_W-1:0]          heap_count,
    input  idmh_pkg::dp_cmd_t                   cmd,
    output idmh_pkg::dp_stat_t                  stat
);

    logic [idmh_pkg::ARITY_W-1:0]  arity_reg;
    idmh_pkg::opcode_t             op_reg;
    logic [idmh_pkg::ID_W-1:0]     id_reg;
    logic [idmh_pkg::KEY_W-1:0]    key_reg;
    logic [idmh_pkg::ID_W-1:0]     item_reg;
    logic [idmh_pkg::KEY_W-1:0]    ikey_reg;
    logic [idmh_pkg::KEY_W-1:0]    k_reg;
    logic [idmh_pkg::ID_W-1:0]     rem_reg;
    logic [idmh_pkg::POS_W-1:0]    x_reg;
    logic [idmh_pkg::POS_W-1:0]    px_reg;
    logic [idmh_pkg::POS_W-1:0]    bpos_reg;
    logic [idmh_pkg::CNT_W-1:0]    size_reg;
    logic [idmh_pkg::CHILD_W-1:0]  y_reg;
    logic [idmh_pkg::CHILD_W-1:0]  lastc_reg;
    idmh_pkg::slot_t               best_reg;
    logic                          bfirst_reg;
    idmh_pkg::status_t             st_reg;
    logic [idmh_pkg::ID_W-1:0]     min_reg;
    logic [idmh_pkg::NUM_ITEMS-1:0] present_reg;
    logic                          out_valid_reg;
    logic [idmh_pkg::ID_W-1:0]     out_min_reg;
    logic [2:0]                    out_st_reg;
    logic [idmh_pkg::CNT_W-1:0]    out_cnt_reg;

    logic [idmh_pkg::ARITY_W-1:0]  eff_d;
    logic [idmh_pkg::CHILD_W-1:0]  first_c;
    logic [idmh_pkg::CHILD_W-1:0]  yn;
    logic [idmh_pkg::PROD_W-1:0]   pprod;
    logic [idmh_pkg::POS_W-1:0]    px_c;

    logic                          slot_we;
    logic [idmh_pkg::POS_W-1:0]    slot_waddr;
    idmh_pkg::slot_t               slot_wdata;
    logic [idmh_pkg::POS_W-1:0]    slot_raddr;
    idmh_pkg::slot_t               slot_rdata;
    logic                          pos_we;
    logic [idmh_pkg::ID_W-1:0]     pos_waddr;
    logic [idmh_pkg::POS_W-1:0]    pos_wdata;
    logic [idmh_pkg::ID_W-1:0]     pos_raddr;
    logic [idmh_pkg::POS_W-1:0]    pos_rdata;

    idmh_ram #(
        .WIDTH (idmh_pkg::SLOT_W),
        .DEPTH (idmh_pkg::NUM_ITEMS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    idmh_ram #(
        .WIDTH (idmh_pkg::POS_W),
        .DEPTH (idmh_pkg::NUM_ITEMS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // clamp arity into the supported range
    always_comb
    begin
        priority if (arity_reg < idmh_pkg::ARITY_W'(idmh_pkg::MIN_ARITY))
            eff_d = idmh_pkg::ARITY_W'(idmh_pkg::MIN_ARITY);
        else if (arity_reg > idmh_pkg::ARITY_W'(idmh_pkg::MAX_ARITY))
            eff_d = idmh_pkg::ARITY_W'(idmh_pkg::MAX_ARITY);
        else
            eff_d = arity_reg;
    end

    assign first_c = idmh_pkg::CHILD_W'(x_reg) * idmh_pkg::CHILD_W'(eff_d)
                   + idmh_pkg::CHILD_W'(1);
    assign yn      = y_reg + idmh_pkg::CHILD_W'(1);
    // parent = (x - 1) / d by reciprocal multiply
    assign pprod   = idmh_pkg::PROD_W'(x_reg - idmh_pkg::POS_W'(1))
                   * idmh_pkg::PROD_W'(idmh_pkg::recip(eff_d));
    assign px_c    = pprod[idmh_pkg::RECIP_SHIFT +: idmh_pkg::POS_W];

    // status to controller
    always_comb
    begin
        stat.op            = op_reg;
        stat.present       = present_reg[id_reg];
        stat.size_zero     = (size_reg == '0);
        stat.x_zero        = (x_reg == '0);
        stat.first_ge_size = (first_c >= idmh_pkg::CHILD_W'(size_reg));
        stat.scan_more     = (yn <= lastc_reg) && (yn < idmh_pkg::CHILD_W'(size_reg));
        stat.up_swap       = (slot_rdata.key > ikey_reg);
        stat.down_swap     = (best_reg.key < ikey_reg);
        stat.same_last     = (slot_rdata.item == rem_reg);
        stat.last_le       = (slot_rdata.key <= k_reg);
        stat.key_lt        = (key_reg < slot_rdata.key);
        stat.key_gt        = (key_reg > slot_rdata.key);
        stat.out_free      = !out_valid_reg || !out_stall;
    end

    // memory ports
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = x_reg;
        slot_wdata = '{item: item_reg, key: ikey_reg};
        slot_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = item_reg;
        pos_wdata  = x_reg;
        pos_raddr  = id_reg;
        unique case (cmd.act)
            idmh_pkg::ACT_RD_OLD:  slot_raddr = pos_rdata;
            idmh_pkg::ACT_RD_LAST: slot_raddr = idmh_pkg::POS_W'(size_reg - idmh_pkg::CNT_W'(1));
            idmh_pkg::ACT_SU_RD:   slot_raddr = px_c;
            idmh_pkg::ACT_SD_RD:   slot_raddr = first_c[idmh_pkg::POS_W-1:0];
            idmh_pkg::ACT_SD_SCAN: slot_raddr = yn[idmh_pkg::POS_W-1:0];
            idmh_pkg::ACT_SU_MOVE:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
                pos_we     = 1'b1;
                pos_waddr  = slot_rdata.item;
            end
            idmh_pkg::ACT_SD_MOVE:
            begin
                slot_we    = 1'b1;
                slot_wdata = best_reg;
                pos_we     = 1'b1;
                pos_waddr  = best_reg.item;
            end
            idmh_pkg::ACT_PLACE:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            default:
            begin
                slot_raddr = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arity_reg     <= idmh_pkg::ARITY_W'(idmh_pkg::MIN_ARITY);
            size_reg      <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
            bfirst_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                arity_reg <= cfg_wr_data;
            end
            unique case (cmd.act)
                idmh_pkg::ACT_INSERT:
                begin
                    size_reg             <= size_reg + idmh_pkg::CNT_W'(1);
                    present_reg[id_reg]  <= 1'b1;
                end
                idmh_pkg::ACT_RD_POS:
                begin
                    if (op_reg == idmh_pkg::OP_REMOVE)
                    begin
                        present_reg[id_reg] <= 1'b0;
                    end
                end
                idmh_pkg::ACT_TAKE_MIN:
                begin
                    present_reg[slot_rdata.item] <= 1'b0;
                end
                idmh_pkg::ACT_RD_LAST:
                begin
                    size_reg <= size_reg - idmh_pkg::CNT_W'(1);
                end
                idmh_pkg::ACT_SD_RD:   bfirst_reg <= 1'b1;
                idmh_pkg::ACT_SD_SCAN: bfirst_reg <= 1'b0;
                default:
                begin
                    bfirst_reg <= bfirst_reg;
                end
            endcase
            if (cmd.act == idmh_pkg::ACT_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.act)
            idmh_pkg::ACT_LOAD:
            begin
                op_reg  <= idmh_pkg::opcode_t'(opcode);
                id_reg  <= item_id;
                key_reg <= new_key;
                st_reg  <= idmh_pkg::ST_OK;
                min_reg <= '0;
            end
            idmh_pkg::ACT_SET_STATUS: st_reg <= cmd.code;
            idmh_pkg::ACT_INSERT:
            begin
                item_reg <= id_reg;
                ikey_reg <= key_reg;
                x_reg    <= size_reg[idmh_pkg::POS_W-1:0];
            end
            idmh_pkg::ACT_RD_POS: rem_reg <= id_reg;
            idmh_pkg::ACT_TAKE_MIN:
            begin
                rem_reg <= slot_rdata.item;
                min_reg <= slot_rdata.item;
                k_reg   <= slot_rdata.key;
                x_reg   <= '0;
            end
            idmh_pkg::ACT_RD_OLD: x_reg <= pos_rdata;
            idmh_pkg::ACT_GOT_OLD:
            begin
                k_reg    <= slot_rdata.key;
                item_reg <= id_reg;
                ikey_reg <= key_reg;
            end
            idmh_pkg::ACT_GOT_LAST:
            begin
                item_reg <= slot_rdata.item;
                ikey_reg <= slot_rdata.key;
            end
            idmh_pkg::ACT_SU_RD:   px_reg <= px_c;
            idmh_pkg::ACT_SU_MOVE: x_reg  <= px_reg;
            idmh_pkg::ACT_SD_RD:
            begin
                y_reg     <= first_c;
                lastc_reg <= first_c + idmh_pkg::CHILD_W'(eff_d) - idmh_pkg::CHILD_W'(1);
            end
            idmh_pkg::ACT_SD_SCAN:
            begin
                if (bfirst_reg || (slot_rdata.key < best_reg.key))
                begin
                    best_reg <= slot_rdata;
                    bpos_reg <= y_reg[idmh_pkg::POS_W-1:0];
                end
                y_reg <= yn;
            end
            idmh_pkg::ACT_SD_MOVE: x_reg <= bpos_reg;
            idmh_pkg::ACT_FINISH:
            begin
                out_min_reg <= min_reg;
                out_st_reg  <= st_reg;
                out_cnt_reg <= size_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign min_item   = out_min_reg;
    assign status     = out_st_reg;
    assign heap_count = out_cnt_reg;

    `IDMH_ASSERT(a_size_bound, clk, rst_n, size_reg <= idmh_pkg::CNT_W'(idmh_pkg::NUM_ITEMS), "heap size beyond item count")
    `IDMH_ASSERT(a_su_not_root, clk, rst_n, (cmd.act == idmh_pkg::ACT_SU_RD) |-> (x_reg != '0), "parent read at root")
    `IDMH_ASSERT(a_insert_grows, clk, rst_n, (cmd.act == idmh_pkg::ACT_INSERT) |=> (size_reg == $past(size_reg) + idmh_pkg::CNT_W'(1)), "insert did not grow heap")
    `IDMH_ASSERT(a_scan_in_heap, clk, rst_n, (cmd.act == idmh_pkg::ACT_SD_SCAN) |-> (y_reg < idmh_pkg::CHILD_W'(size_reg)), "child scan past heap end")
    `IDMH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid_reg || rst_n, "output valid out of reset")

endmodule

FILE: hw/rtl/indexed_dary_min_heap_core.sv
// Top level of the indexed d-ary min-heap core: controller plus datapath.
// Depends on idmh_pkg, idmh_ctrl, idmh_datapath (and idmh_ram below it).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat of opcode, item_id and
//   new_key. Output channel (out_valid / out_stall) returns one beat per input:
//   min_item, status and heap_count after the operation.
//   Arity is written through cfg_wr_en / cfg_wr_data while the core is idle;
//   values outside 2..8 are clamped. Reset leaves arity at 2 and the heap empty.
// Timing:
//   One operation at a time. Insert and a decreasing key change climb level
//   by level (parent read through the slot RAM, then compare and move).
//   Delete-min, remove and an increasing key change run setup steps and
//   then walk down level by level, reading every child key from the slot
//   RAM read port, one per cycle. Removing the root of a full heap is the
//   longest case.
// Stalls:
//   The finished result sits in an output register; the next input beat is
//   taken while it waits. A new result waits in its final step until the
//   previous one has been taken.

module indexed_dary_min_heap_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [idmh_pkg::ARITY_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [idmh_pkg::ID_W-1:0]     item_id,
    input  logic [idmh_pkg::KEY_W-1:0]    new_key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [idmh_pkg::ID_W-1:0]     min_item,
    output logic [2:0]                    status,
    output logic [idmh_pkg::CNT_W-1:0]    heap_count
);

    idmh_pkg::dp_cmd_t  cmd;
    idmh_pkg::dp_stat_t stat;

    // sequencer: one action per cycle
    idmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // heap storage, sift registers, output register
    idmh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .item_id     (item_id),
        .new_key     (new_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_item    (min_item),
        .status      (status),
        .heap_count  (heap_count),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
